// File: rtl/core/philox_counter_prng_unit_macros.svh
// Assertion macros for the Philox counter generator.
// Included by the top level; no other dependencies.
`ifndef PHILOX_COUNTER_PRNG_UNIT_MACROS_SVH
`define PHILOX_COUNTER_PRNG_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define PCP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define PCP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define PCP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/pcp_pkg.sv
// Shared constants and types for the Philox counter generator.
// No dependencies; used by the round cell and the top level.
package pcp_pkg;

    localparam int unsigned PCP_ROUND_COUNT = 10;
    localparam int unsigned PCP_WORD_W      = 32;

    // Round multipliers and Weyl key increments
    localparam logic [PCP_WORD_W-1:0] PCP_MUL_A  = 32'hD251_1F53;
    localparam logic [PCP_WORD_W-1:0] PCP_MUL_B  = 32'hCD9E_8D57;
    localparam logic [PCP_WORD_W-1:0] PCP_WEYL_A = 32'hBB67_AE85;
    localparam logic [PCP_WORD_W-1:0] PCP_WEYL_B = 32'h9E37_79B9;

    // Configuration register indexes
    localparam int unsigned PCP_CFG_IDX_W = 1;
    localparam logic [PCP_CFG_IDX_W-1:0] PCP_REG_KEY_LOW  = 1'b0;
    localparam logic [PCP_CFG_IDX_W-1:0] PCP_REG_KEY_HIGH = 1'b1;

    // One transaction in flight: counter words plus its round keys
    typedef struct packed {
        logic [PCP_WORD_W-1:0] r0;
        logic [PCP_WORD_W-1:0] l0;
        logic [PCP_WORD_W-1:0] r1;
        logic [PCP_WORD_W-1:0] l1;
        logic [PCP_WORD_W-1:0] ka;
        logic [PCP_WORD_W-1:0] kb;
    } t_pcp_lane;

endpackage

// File: rtl/core/pcp_round_cell.sv
// One Philox round as a registered cell of the round chain.
// Depends on pcp_pkg for the lane type and round constants.
module pcp_round_cell
    import pcp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_pcp_lane i_data,
    input  logic      i_ready,
    output logic      o_valid,
    output t_pcp_lane o_data,
    output logic      o_ready
);

    logic                    r_valid;
    t_pcp_lane               r_data;
    t_pcp_lane               n_data;
    logic                    w_ready;
    logic [2*PCP_WORD_W-1:0] w_p;
    logic [2*PCP_WORD_W-1:0] w_q;

    // Take a new transaction when empty or when the held one moves on
    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;

    // Form both full products of the round
    assign w_p = {{PCP_WORD_W{1'b0}}, i_data.r0} * {{PCP_WORD_W{1'b0}}, PCP_MUL_B};
    assign w_q = {{PCP_WORD_W{1'b0}}, i_data.r1} * {{PCP_WORD_W{1'b0}}, PCP_MUL_A};

    // Mix high halves with keys and the other half words, advance the keys
    always_comb begin
        n_data.r0 = w_q[2*PCP_WORD_W-1:PCP_WORD_W] ^ i_data.kb ^ i_data.l1;
        n_data.l0 = w_p[PCP_WORD_W-1:0];
        n_data.r1 = w_p[2*PCP_WORD_W-1:PCP_WORD_W] ^ i_data.ka ^ i_data.l0;
        n_data.l1 = w_q[PCP_WORD_W-1:0];
        n_data.ka = i_data.ka + PCP_WEYL_A;
        n_data.kb = i_data.kb + PCP_WEYL_B;
    end

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the round result
    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/philox_counter_prng_unit.sv
// Throughput: one counter per cycle while the result is not stalled, set by the chain
// of registered round cells, each doing one round with its two 32x32 multiplies.
// A stalled result holds its own cell and the full cells behind it; empty cells upstream keep filling.
// Reset (synchronous, active low) clears all valid flags and both key registers.
module philox_counter_prng_unit
    import pcp_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = PCP_ROUND_COUNT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [PCP_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PCP_WORD_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [PCP_WORD_W-1:0]    i_count_word0,
    input  logic [PCP_WORD_W-1:0]    i_count_word1,
    input  logic [PCP_WORD_W-1:0]    i_count_word2,
    input  logic [PCP_WORD_W-1:0]    i_count_word3,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [PCP_WORD_W-1:0]    o_rand_word0,
    output logic [PCP_WORD_W-1:0]    o_rand_word1,
    output logic [PCP_WORD_W-1:0]    o_rand_word2,
    output logic [PCP_WORD_W-1:0]    o_rand_word3
);

`include "philox_counter_prng_unit_macros.svh"

    logic [PCP_WORD_W-1:0] r_key_low;
    logic [PCP_WORD_W-1:0] r_key_high;

    logic      w_valid [0:ROUND_COUNT];
    logic      w_ready [0:ROUND_COUNT];
    t_pcp_lane w_data  [0:ROUND_COUNT];
    logic      w_chain_full;

    // Write the key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                PCP_REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                PCP_REG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Feed the chain head with the counter and the written key
    assign w_valid[0]   = i_in_valid;
    assign w_data[0].r0 = i_count_word0;
    assign w_data[0].l0 = i_count_word1;
    assign w_data[0].r1 = i_count_word2;
    assign w_data[0].l1 = i_count_word3;
    assign w_data[0].ka = r_key_low;
    assign w_data[0].kb = r_key_high;
    assign o_in_stall   = !w_ready[0];

    // Build the chain of round cells
    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        pcp_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .i_ready (w_ready[g+1]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1]),
            .o_ready (w_ready[g])
        );
    end

    // Drive the result from the last cell
    assign w_ready[ROUND_COUNT] = !i_out_stall;
    assign o_out_valid  = w_valid[ROUND_COUNT];
    assign o_rand_word0 = w_data[ROUND_COUNT].r0;
    assign o_rand_word1 = w_data[ROUND_COUNT].l0;
    assign o_rand_word2 = w_data[ROUND_COUNT].r1;
    assign o_rand_word3 = w_data[ROUND_COUNT].l1;

    // Flag a chain with every cell occupied
    always_comb begin
        w_chain_full = 1'b1;
        for (int k = 1; k <= ROUND_COUNT; k++) begin
            w_chain_full = w_chain_full & w_valid[k];
        end
    end

    // Input may stall only behind a waiting result
    `PCP_ASSERT_IMPL(a_stall_needs_result, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without a stalled result")
    // A full chain with a stalled result must stall the input
    `PCP_ASSERT_IMPL(a_full_chain_stalls, i_clk, i_rst_n, w_chain_full && i_out_stall, o_in_stall, "full chain did not stall input")
    // A result that is stalled is still there next cycle
    `PCP_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "stalled result dropped by the chain")

endmodule

// File: test/tb_philox_counter_prng_unit.sv
// Testbench for philox_counter_prng_unit: 128-bit counters in, 128-bit random blocks out.
// Depends on pcp_pkg and the RTL top level; results are checked against an in-bench
// model of the ten keyed rounds, with random idling on both channels.
`timescale 1ns / 100ps

module tb_philox_counter_prng_unit;
    import pcp_pkg::*;

    localparam int unsigned DRAIN_CYCLES = PCP_ROUND_COUNT + 4;
    localparam int unsigned STUCK_LIMIT  = 2000;
    localparam int unsigned PHASE_ITEMS  = 100;
    localparam int unsigned PHASE_COUNT  = 4;
    localparam int unsigned REPORT_MAX   = 10;

    // Four 32-bit words, word 0 first; used for counters and random blocks
    typedef struct packed {
        logic [PCP_WORD_W-1:0] w0;
        logic [PCP_WORD_W-1:0] w1;
        logic [PCP_WORD_W-1:0] w2;
        logic [PCP_WORD_W-1:0] w3;
    } t_block;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [PCP_CFG_IDX_W-1:0] i_cfg_index   = PCP_REG_KEY_LOW;
    logic [PCP_WORD_W-1:0]    i_cfg_data    = '0;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_stall;
    logic [PCP_WORD_W-1:0]    i_count_word0 = '0;
    logic [PCP_WORD_W-1:0]    i_count_word1 = '0;
    logic [PCP_WORD_W-1:0]    i_count_word2 = '0;
    logic [PCP_WORD_W-1:0]    i_count_word3 = '0;
    logic                     o_out_valid;
    logic                     i_out_stall   = 1'b1;
    logic [PCP_WORD_W-1:0]    o_rand_word0;
    logic [PCP_WORD_W-1:0]    o_rand_word1;
    logic [PCP_WORD_W-1:0]    o_rand_word2;
    logic [PCP_WORD_W-1:0]    o_rand_word3;

    // Key as written to the block, and blocks still owed by it
    logic [PCP_WORD_W-1:0] key_low_q  = '0;
    logic [PCP_WORD_W-1:0] key_high_q = '0;
    t_block                pending_blocks[$];
    int unsigned           mismatch_count = 0;
    int unsigned           stuck_cycles   = 0;
    bit                    calm           = 1'b0;

    philox_counter_prng_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_count_word0 (i_count_word0),
        .i_count_word1 (i_count_word1),
        .i_count_word2 (i_count_word2),
        .i_count_word3 (i_count_word3),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rand_word0  (o_rand_word0),
        .o_rand_word1  (o_rand_word1),
        .o_rand_word2  (o_rand_word2),
        .o_rand_word3  (o_rand_word3)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run all rounds on one counter with the current key
    function automatic t_block philox_block(input t_block ctr,
                                            input logic [PCP_WORD_W-1:0] key_lo,
                                            input logic [PCP_WORD_W-1:0] key_hi);
        logic [PCP_WORD_W-1:0] r0, l0, r1, l1, ka, kb;
        logic [2*PCP_WORD_W-1:0] p, q;
        int n;
        r0 = ctr.w0;
        l0 = ctr.w1;
        r1 = ctr.w2;
        l1 = ctr.w3;
        ka = key_lo;
        kb = key_hi;
        for (n = 0; n < PCP_ROUND_COUNT; n++) begin
            p  = {32'd0, r0} * {32'd0, PCP_MUL_B};
            q  = {32'd0, r1} * {32'd0, PCP_MUL_A};
            r0 = q[63:32] ^ kb ^ l1;
            r1 = p[63:32] ^ ka ^ l0;
            l0 = p[31:0];
            l1 = q[31:0];
            ka = ka + PCP_WEYL_A;
            kb = kb + PCP_WEYL_B;
        end
        return '{w0: r0, w1: l0, w2: r1, w3: l1};
    endfunction

    // Receiver: stall about a quarter of the cycles unless in a calm stretch
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 25);
    end

    // Check each result against the oldest owed block, then record new counters
    always @(posedge i_clk) begin : check_results
        t_block got;
        t_block want;
        logic [3:0] bad;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_rand_word0, o_rand_word1, o_rand_word2, o_rand_word3};
                if (pending_blocks.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected result %h", $realtime, got);
                end else begin
                    want = pending_blocks.pop_front();
                    bad  = {got.w0 !== want.w0, got.w1 !== want.w1,
                            got.w2 !== want.w2, got.w3 !== want.w3};
                    if (|bad) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: words %b wrong: expected %h got %h",
                                     $realtime, bad, want, got);
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                pending_blocks.push_back(philox_block(
                    {i_count_word0, i_count_word1, i_count_word2, i_count_word3},
                    key_low_q, key_high_q));
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one counter, with random idle cycles ahead of it; return once accepted
    task automatic send_counter(input t_block ctr);
        while (!calm && ($urandom_range(99) < 25)) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        {i_count_word0, i_count_word1, i_count_word2, i_count_word3} <= ctr;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Drop valid and hold until every owed block has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(negedge i_clk);
    endtask

    // Write one key register; only called with nothing in flight
    task automatic write_key(input logic [PCP_CFG_IDX_W-1:0] idx,
                             input logic [PCP_WORD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            PCP_REG_KEY_LOW:  key_low_q  = value;
            PCP_REG_KEY_HIGH: key_high_q = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_key(input logic [PCP_WORD_W-1:0] lo, input logic [PCP_WORD_W-1:0] hi);
        wait_drained();
        write_key(PCP_REG_KEY_LOW, lo);
        write_key(PCP_REG_KEY_HIGH, hi);
    endtask

    // Zero key from reset, counter word extremes and bit patterns
    task automatic test_reset_key();
        send_counter('0);
        send_counter('1);
        send_counter({4{32'h8000_0000}});
        send_counter({4{32'h0000_0001}});
        send_counter({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
        send_counter({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0});
        send_counter({32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF});
    endtask

    // Key extremes; a repeated counter must give the same block again
    task automatic test_key_extremes();
        set_key(32'hFFFF_FFFF, 32'h0);
        send_counter('0);
        send_counter('1);
        set_key(32'h0, 32'hFFFF_FFFF);
        send_counter('0);
        send_counter('1);
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_counter('0);
        send_counter('1);
        send_counter({32'd3, 32'd2, 32'd1, 32'd0});
        send_counter({32'd3, 32'd2, 32'd1, 32'd0});
    endtask

    // Rewrite one key word while the other keeps its value
    task automatic test_single_register();
        wait_drained();
        write_key(PCP_REG_KEY_LOW, $urandom());
        send_counter({$urandom(), $urandom(), $urandom(), $urandom()});
        wait_drained();
        write_key(PCP_REG_KEY_HIGH, $urandom());
        send_counter({$urandom(), $urandom(), $urandom(), $urandom()});
    endtask

    // Random keys per phase; random, sequential, word-extreme and sparse counters
    task automatic test_random();
        logic [127:0] seq_ctr;
        t_block ctr;
        int unsigned kind;
        int unsigned phase;
        int unsigned item;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            set_key($urandom(), $urandom());
            seq_ctr = {$urandom(), $urandom(), $urandom(), $urandom()};
            calm = (phase == 2);
            for (item = 0; item < PHASE_ITEMS; item++) begin
                kind = $urandom_range(99);
                if (kind < 40) begin
                    ctr = {$urandom(), $urandom(), $urandom(), $urandom()};
                end else if (kind < 70) begin
                    // advance a counter as a Monte Carlo stream would
                    ctr     = seq_ctr;
                    seq_ctr = seq_ctr + 128'd1;
                end else if (kind < 85) begin
                    ctr = {$urandom(), $urandom(), $urandom(), $urandom()};
                    if ($urandom_range(1)) ctr.w0 = $urandom_range(1) ? '1 : '0;
                    if ($urandom_range(1)) ctr.w1 = $urandom_range(1) ? '1 : '0;
                    if ($urandom_range(1)) ctr.w2 = 32'h8000_0000;
                    if ($urandom_range(1)) ctr.w3 = 32'h0000_0001;
                end else begin
                    ctr = '0;
                    case ($urandom_range(3))
                        0: ctr.w0 = $urandom();
                        1: ctr.w1 = $urandom();
                        2: ctr.w2 = $urandom();
                        default: ctr.w3 = $urandom();
                    endcase
                end
                send_counter(ctr);
                // hold off the sender until the pipeline empties once
                if (phase == 1 && item == PHASE_ITEMS / 2)
                    wait_drained();
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_key();
        test_key_extremes();
        test_single_register();
        test_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_blocks.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
